[rtl/gha_pkg.sv]
// types and constants shared by the handle allocator modules
package gha_pkg;

  // table size, top generation and recycle tries, fixed to the field widths below
  localparam int CAPACITY       = 1024;
  localparam int MAX_GENERATION = 255;
  localparam int RECYCLE_TRIES  = 5;

  typedef enum logic [1:0] {
    REQ_SPAWN   = 2'd0,
    REQ_KILL    = 2'd1,
    REQ_ALIVE   = 2'd2,
    REQ_CLEANUP = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [9:0] handle_index;
    logic [7:0] handle_generation;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  out_index;
    logic [7:0]  out_generation;
    logic        alive;
    logic [10:0] cleaned_count;
  } rsp_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_LATCH     = 4'd1,  // capture request
    OP_POP_RD    = 4'd2,  // pop free stack, read its entry
    OP_POP_GEN   = 4'd3,  // read generation of popped index
    OP_POP_EVAL  = 4'd4,  // decide on popped index
    OP_FRESH     = 4'd5,  // hand out fresh index or flag full
    OP_HGEN      = 4'd6,  // read generation of request handle
    OP_KILL      = 4'd7,  // apply kill
    OP_ALIVE     = 4'd8,  // report alive
    OP_CL_RD     = 4'd9,  // read tombstone entry
    OP_CL_WB     = 4'd10, // recycle tombstone entry
    OP_CL_DONE   = 4'd11  // report cleanup
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       free_empty;   // free stack empty
    logic       pop_ok;       // popped index reusable
    logic       tries_done;   // recycle tries spent
    logic       tomb_done;    // cleanup walk finished
  } sts_t;

endpackage

[rtl/gha_ctrl.sv]
// controller state machine of the handle allocator
module gha_ctrl import gha_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_POP   = 4'd2;
  localparam logic [3:0] S_PGEN  = 4'd3;
  localparam logic [3:0] S_PEVAL = 4'd4;
  localparam logic [3:0] S_FRESH = 4'd5;
  localparam logic [3:0] S_HGEN  = 4'd6;
  localparam logic [3:0] S_KILL  = 4'd7;
  localparam logic [3:0] S_ALIVE = 4'd8;
  localparam logic [3:0] S_CLRD  = 4'd9;
  localparam logic [3:0] S_CLWB  = 4'd10;
  localparam logic [3:0] S_CLEND = 4'd11;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LATCH;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.req_type)
          REQ_SPAWN:   state_d = S_POP;
          REQ_KILL:    state_d = S_HGEN;
          REQ_ALIVE:   state_d = S_HGEN;
          default:     state_d = S_CLRD;
        endcase
      end
      S_POP: begin
        if (sts_i.free_empty || sts_i.tries_done) begin
          state_d = S_FRESH;
        end else begin
          cmd_o.op = OP_POP_RD;
          state_d = S_PGEN;
        end
      end
      S_PGEN: begin
        cmd_o.op = OP_POP_GEN;
        state_d = S_PEVAL;
      end
      S_PEVAL: begin
        cmd_o.op = OP_POP_EVAL;
        state_d = sts_i.pop_ok ? S_IDLE : S_POP;
      end
      S_FRESH: begin
        cmd_o.op = OP_FRESH;
        state_d = S_IDLE;
      end
      S_HGEN: begin
        cmd_o.op = OP_HGEN;
        state_d = (sts_i.req_type == REQ_KILL) ? S_KILL : S_ALIVE;
      end
      S_KILL: begin
        cmd_o.op = OP_KILL;
        state_d = S_IDLE;
      end
      S_ALIVE: begin
        cmd_o.op = OP_ALIVE;
        state_d = S_IDLE;
      end
      S_CLRD: begin
        if (sts_i.tomb_done) begin
          state_d = S_CLEND;
        end else begin
          cmd_o.op = OP_CL_RD;
          state_d = S_CLWB;
        end
      end
      S_CLWB: begin
        cmd_o.op = OP_CL_WB;
        state_d = S_CLRD;
      end
      S_CLEND: begin
        cmd_o.op = OP_CL_DONE;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

[rtl/gha_dp.sv]
// datapath of the handle allocator: generation table, stacks and counters
module gha_dp import gha_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;
  localparam int GW = $clog2(MAX_GENERATION + 1);
  localparam int TW = $clog2(RECYCLE_TRIES + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);
  localparam logic [GW-1:0] GMAX = GW'(MAX_GENERATION);

  logic [GW-1:0] gen_mem  [CAPACITY];
  logic [AW-1:0] free_mem [CAPACITY];
  logic [AW-1:0] tomb_mem [CAPACITY];

  req_t          req_q;
  logic [CW-1:0] free_cnt_q, tomb_cnt_q, used_cnt_q, walk_q, cleaned_q;
  logic [TW-1:0] tries_q;
  logic [CW-1:0] idx_q;        // popped index, wide for range check
  logic [GW-1:0] gen_rd_q;
  logic          rsp_valid_q, rsp_valid_d;
  rsp_t          rsp_q, rsp_d;

  // generation table port
  logic          gen_we;
  logic [AW-1:0] gen_waddr, gen_raddr;
  logic [GW-1:0] gen_wdata;
  logic          gen_re;
  // free stack port
  logic          free_we;
  logic [AW-1:0] free_waddr;
  logic [AW-1:0] free_wdata;
  logic [AW-1:0] free_rd_q, tomb_rd_q;
  // tombstone stack port
  logic          tomb_we;
  logic [AW-1:0] tomb_waddr, tomb_wdata;

  logic [CW-1:0] hidx_w;
  logic [GW-1:0] hgen_w;
  logic          idx_in_range, pop_ok, hmatch;

  assign hidx_w = CW'(req_q.handle_index);
  assign hgen_w = GW'(req_q.handle_generation);
  // popped index, registered from the free stack read, is in idx_q
  assign idx_in_range = (idx_q < used_cnt_q);
  assign pop_ok = idx_in_range && (gen_rd_q < GMAX);
  assign hmatch = (hidx_w < used_cnt_q) && (gen_rd_q == hgen_w);

  assign sts_o.req_type   = req_q.req_type;
  assign sts_o.free_empty = (free_cnt_q == '0);
  assign sts_o.pop_ok     = pop_ok;
  assign sts_o.tries_done = (tries_q == TW'(RECYCLE_TRIES));
  assign sts_o.tomb_done  = (walk_q >= tomb_cnt_q);

  // memory port control
  always_comb begin
    gen_we = 1'b0; gen_waddr = '0; gen_wdata = '0;
    gen_re = 1'b0; gen_raddr = '0;
    free_we = 1'b0; free_waddr = '0; free_wdata = '0;
    tomb_we = 1'b0; tomb_waddr = '0; tomb_wdata = '0;
    case (cmd_i.op)
      OP_POP_GEN: begin
        gen_re = 1'b1; gen_raddr = free_rd_q;
      end
      OP_POP_EVAL: begin
        if (!pop_ok && tomb_cnt_q < CAP) begin
          tomb_we = 1'b1; tomb_waddr = tomb_cnt_q[AW-1:0]; tomb_wdata = idx_q[AW-1:0];
        end
      end
      OP_FRESH: begin
        if (used_cnt_q < CAP) begin
          gen_we = 1'b1; gen_waddr = used_cnt_q[AW-1:0]; gen_wdata = '0;
        end
      end
      OP_HGEN: begin
        gen_re = 1'b1; gen_raddr = req_q.handle_index[AW-1:0];
      end
      OP_KILL: begin
        if (hmatch) begin
          gen_we = 1'b1; gen_waddr = hidx_w[AW-1:0];
          if (gen_rd_q >= GMAX - GW'(1)) begin
            gen_wdata = GMAX;
            if (tomb_cnt_q < CAP) begin
              tomb_we = 1'b1; tomb_waddr = tomb_cnt_q[AW-1:0];
              tomb_wdata = hidx_w[AW-1:0];
            end
          end else begin
            gen_wdata = gen_rd_q + GW'(1);
            if (free_cnt_q < CAP) begin
              free_we = 1'b1; free_waddr = free_cnt_q[AW-1:0];
              free_wdata = hidx_w[AW-1:0];
            end
          end
        end
      end
      OP_CL_WB: begin
        if (tomb_rd_q < used_cnt_q[AW-1:0] || used_cnt_q == CAP) begin
          gen_we = 1'b1; gen_waddr = tomb_rd_q; gen_wdata = '0;
          if (free_cnt_q < CAP) begin
            free_we = 1'b1; free_waddr = free_cnt_q[AW-1:0]; free_wdata = tomb_rd_q;
          end
        end
      end
      default: ;
    endcase
  end

  // result beat of the finishing operation
  always_comb begin
    rsp_valid_d = 1'b0;
    rsp_d = '0;
    case (cmd_i.op)
      OP_POP_EVAL: begin
        if (pop_ok) begin
          rsp_valid_d = 1'b1;
          rsp_d.out_index = 10'(idx_q);
          rsp_d.out_generation = 8'(gen_rd_q);
        end
      end
      OP_FRESH: begin
        rsp_valid_d = 1'b1;
        if (used_cnt_q < CAP) begin
          rsp_d.out_index = 10'(used_cnt_q);
        end else begin
          rsp_d.status = ST_FULL;
        end
      end
      OP_KILL: begin
        rsp_valid_d = 1'b1;
        if (!hmatch) rsp_d.status = ST_STALE;
      end
      OP_ALIVE: begin
        rsp_valid_d = 1'b1;
        rsp_d.alive = hmatch;
      end
      OP_CL_DONE: begin
        rsp_valid_d = 1'b1;
        rsp_d.cleaned_count = 11'(cleaned_q);
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (gen_we) gen_mem[gen_waddr] <= gen_wdata;
    if (gen_re) gen_rd_q <= gen_mem[gen_raddr];
    if (free_we) free_mem[free_waddr] <= free_wdata;
    if (cmd_i.op == OP_POP_RD) free_rd_q <= free_mem[free_cnt_q[AW-1:0] - AW'(1)];
    if (tomb_we) tomb_mem[tomb_waddr] <= tomb_wdata;
    if (cmd_i.op == OP_CL_RD) tomb_rd_q <= tomb_mem[walk_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) req_q <= req_i;
    if (cmd_i.op == OP_POP_GEN) idx_q <= CW'(free_rd_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_cnt_q <= '0; tomb_cnt_q <= '0; used_cnt_q <= '0;
      walk_q <= '0; cleaned_q <= '0; tries_q <= '0;
      rsp_valid_q <= 1'b0; rsp_q <= '0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      rsp_q <= rsp_d;
      if (free_we) free_cnt_q <= free_cnt_q + CW'(1);
      if (tomb_we && cmd_i.op != OP_CL_WB) tomb_cnt_q <= tomb_cnt_q + CW'(1);
      case (cmd_i.op)
        OP_LATCH: begin
          tries_q <= '0; walk_q <= '0; cleaned_q <= '0;
        end
        OP_POP_RD: free_cnt_q <= free_cnt_q - CW'(1);
        OP_POP_EVAL: tries_q <= tries_q + TW'(1);
        OP_FRESH: begin
          if (used_cnt_q < CAP) used_cnt_q <= used_cnt_q + CW'(1);
        end
        OP_CL_WB: begin
          walk_q <= walk_q + CW'(1);
          if (free_we) cleaned_q <= cleaned_q + CW'(1);
        end
        OP_CL_DONE: tomb_cnt_q <= '0;
        default: ;
      endcase
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o = rsp_q;

endmodule

[rtl/generational_handle_allocator.sv]
// top level of the generational handle allocator
// A request beat is taken when start is high and busy is low; each request gives
// exactly one result beat, shown for one cycle with done_o high, and the receiver
// cannot stall it. Timing is set by the single-port generation table and stacks,
// each read through a register. is_alive and kill latch the request, dispatch it
// and read the handle's generation before the result; spawn pops an index, reads
// its generation and checks it, rejecting at most 5 popped indexes before it falls
// back to a fresh index, as it also does when the free stack is empty; cleanup
// reads and writes back each tombstone walked, then reports. busy drops in the
// cycle of the result beat, so the next request can be taken at the same edge.
// Table size, top generation and recycle tries are fixed in the package. No
// clearing pass after reset: table and stacks are only used below their fill counts.
module generational_handle_allocator import gha_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // controller sequences the memory accesses of each request
  gha_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // datapath holds the table, both stacks and the counters
  gha_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_valid_o(done_o),
    .rsp_o      (rsp_o)
  );

endmodule

[rtl/gha_checker.sv]
// port-level checker for the handle allocator, bound to the top level
module gha_checker import gha_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic done,
  input rsp_t rsp_o
);

  // a result beat only while a request is in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> $past(busy)) else $error("result without request");

  // accepted request makes the block busy next cycle
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request not taken");

  // block is idle during the result beat
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !busy) else $error("busy after result");

  // status code stays in range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (rsp_o.status != 2'd3)) else $error("bad status");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .req_i (req_i),
  .done  (done_o),
  .rsp_o (rsp_o)
);
